FILE: rtl/gda_pkg.sv
package gda_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DIFF = 2'd1;
    localparam logic [1:0] KIND_DOY  = 2'd2;

    localparam logic [13:0] YEAR_LIMIT = 14'd9999;
    // floor(y / 100) == (y * RECIP100) >> 20 for every 14-bit y
    localparam logic [13:0] RECIP100   = 14'd10486;
    localparam logic [22:0] DAYS_YEAR  = 23'd365;

    localparam logic signed [23:0] DN_MAX = 24'sd4194303;
    localparam logic signed [23:0] DN_MIN = -24'sd4194304;

    typedef logic [3:0] uaddr_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD1,
        OP_LOAD2,
        OP_MUL,
        OP_SPLIT,
        OP_TERM,
        OP_SUB_S,
        OP_ADD_S,
        OP_DOY,
        OP_STEP,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_KIND_BAD,
        C_KIND_ADD,
        C_KIND_DOY,
        C_ADD_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        uaddr_t target;
    } uword_t;

    typedef struct packed {
        logic kind_add;
        logic kind_doy;
        logic kind_bad;
        logic add_busy;
        logic out_busy;
    } dp_status_t;

    localparam uaddr_t A_IDLE  = 4'd0;
    localparam uaddr_t A_LOAD1 = 4'd1;
    localparam uaddr_t A_DOY   = 4'd12;
    localparam uaddr_t A_STEP  = 4'd13;
    localparam uaddr_t A_FIN   = 4'd14;

    // control store: taken jump goes to target, otherwise fall through
    function automatic uword_t ucode(input uaddr_t addr);
        uword_t w;
        case (addr)
            4'd0:    w = '{OP_NOP,    C_NO_START, A_IDLE};
            4'd1:    w = '{OP_LOAD1,  C_KIND_BAD, A_FIN};
            4'd2:    w = '{OP_MUL,    C_NEVER,    A_IDLE};
            4'd3:    w = '{OP_SPLIT,  C_KIND_ADD, A_STEP};
            4'd4:    w = '{OP_NOP,    C_KIND_DOY, A_DOY};
            4'd5:    w = '{OP_TERM,   C_NEVER,    A_IDLE};
            4'd6:    w = '{OP_SUB_S,  C_NEVER,    A_IDLE};
            4'd7:    w = '{OP_LOAD2,  C_NEVER,    A_IDLE};
            4'd8:    w = '{OP_MUL,    C_NEVER,    A_IDLE};
            4'd9:    w = '{OP_SPLIT,  C_NEVER,    A_IDLE};
            4'd10:   w = '{OP_TERM,   C_NEVER,    A_IDLE};
            4'd11:   w = '{OP_ADD_S,  C_ALWAYS,   A_FIN};
            4'd12:   w = '{OP_DOY,    C_ALWAYS,   A_FIN};
            4'd13:   w = '{OP_STEP,   C_ADD_BUSY, A_STEP};
            4'd14:   w = '{OP_FINISH, C_OUT_BUSY, A_FIN};
            4'd15:   w = '{OP_NOP,    C_ALWAYS,   A_IDLE};
            default: w = '{OP_NOP,    C_ALWAYS,   A_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:                      n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // days in the months before m of a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] c;
        if (m == 4'd0)
        begin
            c = 4'd1;
        end
        else if (m > 4'd12)
        begin
            c = 4'd12;
        end
        else
        begin
            c = m;
        end
        return c;
    endfunction

endpackage

FILE: rtl/gda_seq.sv
module gda_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gda_pkg::dp_status_t status,
    output gda_pkg::op_t        op,
    output logic                idle
);

    gda_pkg::uaddr_t pc_reg;
    gda_pkg::uaddr_t pc_next;
    gda_pkg::uword_t uw;
    logic            take;

    assign uw   = gda_pkg::ucode(pc_reg);
    assign op   = uw.op;
    assign idle = (pc_reg == gda_pkg::A_IDLE);

    always_comb
    begin
        case (uw.cond)
            gda_pkg::C_NEVER:    take = 1'b0;
            gda_pkg::C_ALWAYS:   take = 1'b1;
            gda_pkg::C_NO_START: take = !start;
            gda_pkg::C_KIND_BAD: take = status.kind_bad;
            gda_pkg::C_KIND_ADD: take = status.kind_add;
            gda_pkg::C_KIND_DOY: take = status.kind_doy;
            gda_pkg::C_ADD_BUSY: take = status.add_busy;
            gda_pkg::C_OUT_BUSY: take = status.out_busy;
            default:             take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= gda_pkg::A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/gda_dp.sv
module gda_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gda_pkg::op_t        op,
    input  logic [1:0]          in_kind,
    input  logic [4:0]          in_first_day,
    input  logic [3:0]          in_first_month,
    input  logic [13:0]         in_first_year,
    input  logic [4:0]          in_second_day,
    input  logic [3:0]          in_second_month,
    input  logic [13:0]         in_second_year,
    input  logic [15:0]         in_day_count,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [4:0]          result_day,
    output logic [3:0]          result_month,
    output logic [13:0]         result_year,
    output logic [22:0]         day_number,
    output logic                year_overflow,
    output gda_pkg::dp_status_t status
);

    // captured item
    logic [1:0]  kind_reg;
    logic [4:0]  d1_reg;
    logic [3:0]  m1_reg;
    logic [13:0] y1_reg;
    logic [4:0]  d2_reg;
    logic [3:0]  m2_reg;
    logic [13:0] y2_reg;
    logic [15:0] cnt_reg;

    // working registers
    logic [16:0]        d_reg,    d_next;
    logic [3:0]         m_reg,    m_next;
    logic [13:0]        y_reg,    y_next;
    logic               ovf_reg,  ovf_next;
    logic [27:0]        prod_reg, prod_next;
    logic [7:0]         q_reg,    q_next;
    logic [6:0]         r100_reg, r100_next;
    logic [1:0]         c400_reg, c400_next;
    logic [22:0]        term_reg, term_next;
    logic signed [23:0] acc_reg,  acc_next;

    // result word
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         out_day_reg;
    logic [3:0]         out_month_reg;
    logic [13:0]        out_year_reg;
    logic [22:0]        out_dn_reg;
    logic               out_ovf_reg;

    logic               leap;
    logic [4:0]         len;
    logic [8:0]         ylen;
    logic               add_busy;
    logic               year_skip;
    logic [8:0]         ord;
    logic [22:0]        s_date;
    logic [14:0]        r_full;
    logic [7:0]         q_prev;
    logic [13:0]        y_m1;
    logic [11:0]        leaps_before;
    logic [22:0]        y_days;
    logic [13:0]        y_inc;
    logic [6:0]         r_inc;
    logic [1:0]         c_inc;
    logic               ovf_inc;
    logic               out_free;
    logic               out_we;
    logic               is_add;
    logic signed [23:0] acc_sat;

    // leap rule from the year residues: y mod 4, y mod 100 and (y div 100) mod 4
    assign leap = ((y_reg[1:0] == 2'd0) && (r100_reg != 7'd0))
                || ((r100_reg == 7'd0) && (c400_reg == 2'd0));
    assign len  = ((m_reg == 4'd2) && leap) ? 5'd29 : gda_pkg::month_len(m_reg);
    assign ylen = leap ? 9'd366 : 9'd365;

    assign add_busy  = !ovf_reg && (d_reg > {12'd0, len});
    assign year_skip = (m_reg == 4'd1) && (d_reg > {8'd0, ylen});

    assign ord = {4'd0, d_reg[4:0]} + gda_pkg::cum_days(m_reg)
               + (((m_reg > 4'd2) && leap) ? 9'd1 : 9'd0);
    assign s_date = term_reg + {14'd0, ord};

    assign r_full = {1'b0, y_reg} - ({7'd0, q_next} * 15'd100);

    // leap days in years 0 .. y-1, year 0 counted as leap
    assign q_prev = (r100_reg == 7'd0) ? q_reg - 8'd1 : q_reg;
    assign y_m1   = y_reg - 14'd1;
    assign leaps_before = (y_reg == 14'd0) ? 12'd0
                        : y_m1[13:2] - {4'd0, q_prev} + {6'd0, q_prev[7:2]} + 12'd1;
    assign y_days = {9'd0, y_reg} * gda_pkg::DAYS_YEAR;

    assign y_inc   = y_reg + 14'd1;
    assign r_inc   = (r100_reg == 7'd99) ? 7'd0 : r100_reg + 7'd1;
    assign c_inc   = (r100_reg == 7'd99) ? c400_reg + 2'd1 : c400_reg;
    assign ovf_inc = (y_reg >= gda_pkg::YEAR_LIMIT);

    assign out_free = !out_valid_reg || out_ready;
    assign out_we   = (op == gda_pkg::OP_FINISH) && out_free;
    assign is_add   = (kind_reg == gda_pkg::KIND_ADD);

    assign acc_sat = (acc_reg > gda_pkg::DN_MAX) ? gda_pkg::DN_MAX
                   : (acc_reg < gda_pkg::DN_MIN) ? gda_pkg::DN_MIN : acc_reg;

    assign status.kind_add = is_add;
    assign status.kind_doy = (kind_reg == gda_pkg::KIND_DOY);
    assign status.kind_bad = (kind_reg != gda_pkg::KIND_ADD)
                          && (kind_reg != gda_pkg::KIND_DIFF)
                          && (kind_reg != gda_pkg::KIND_DOY);
    assign status.add_busy = add_busy;
    assign status.out_busy = !out_free;

    always_comb
    begin
        d_next    = d_reg;
        m_next    = m_reg;
        y_next    = y_reg;
        ovf_next  = ovf_reg;
        prod_next = prod_reg;
        q_next    = prod_reg[27:20];
        r100_next = r100_reg;
        c400_next = c400_reg;
        term_next = term_reg;
        acc_next  = acc_reg;
        case (op)
            gda_pkg::OP_LOAD1:
            begin
                d_next   = {12'd0, d1_reg} + (is_add ? {1'b0, cnt_reg} : 17'd0);
                m_next   = gda_pkg::clamp_month(m1_reg);
                y_next   = y1_reg;
                ovf_next = (y1_reg > gda_pkg::YEAR_LIMIT);
                acc_next = '0;
            end
            gda_pkg::OP_LOAD2:
            begin
                d_next = {12'd0, d2_reg};
                m_next = gda_pkg::clamp_month(m2_reg);
                y_next = y2_reg;
            end
            gda_pkg::OP_MUL:
            begin
                prod_next = {14'd0, y_reg} * {14'd0, gda_pkg::RECIP100};
            end
            gda_pkg::OP_SPLIT:
            begin
                r100_next = r_full[6:0];
                c400_next = q_next[1:0];
            end
            gda_pkg::OP_TERM:
            begin
                q_next    = q_reg;
                term_next = y_days + {11'd0, leaps_before};
            end
            gda_pkg::OP_SUB_S:
            begin
                q_next   = q_reg;
                acc_next = acc_reg - $signed({1'b0, s_date});
            end
            gda_pkg::OP_ADD_S:
            begin
                q_next   = q_reg;
                acc_next = acc_reg + $signed({1'b0, s_date});
            end
            gda_pkg::OP_DOY:
            begin
                q_next   = q_reg;
                acc_next = $signed({15'd0, ord});
            end
            gda_pkg::OP_STEP:
            begin
                q_next = q_reg;
                if (add_busy)
                begin
                    if (year_skip)
                    begin
                        // whole year left: drop it in one step
                        d_next    = d_reg - {8'd0, ylen};
                        y_next    = y_inc;
                        r100_next = r_inc;
                        c400_next = c_inc;
                        ovf_next  = ovf_inc;
                    end
                    else
                    begin
                        d_next = d_reg - {12'd0, len};
                        if (m_reg == 4'd12)
                        begin
                            m_next    = 4'd1;
                            y_next    = y_inc;
                            r100_next = r_inc;
                            c400_next = c_inc;
                            ovf_next  = ovf_inc;
                        end
                        else
                        begin
                            m_next = m_reg + 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_we)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg <= in_kind;
            d1_reg   <= in_first_day;
            m1_reg   <= in_first_month;
            y1_reg   <= in_first_year;
            d2_reg   <= in_second_day;
            m2_reg   <= in_second_month;
            y2_reg   <= in_second_year;
            cnt_reg  <= in_day_count;
        end
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        ovf_reg  <= ovf_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r100_reg <= r100_next;
        c400_reg <= c400_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        if (out_we)
        begin
            // saturate the sum date on overflow, zero the unused fields
            if (is_add && ovf_reg)
            begin
                out_day_reg   <= 5'd31;
                out_month_reg <= 4'd12;
                out_year_reg  <= gda_pkg::YEAR_LIMIT;
            end
            else if (is_add)
            begin
                out_day_reg   <= d_reg[4:0];
                out_month_reg <= m_reg;
                out_year_reg  <= y_reg;
            end
            else
            begin
                out_day_reg   <= 5'd0;
                out_month_reg <= 4'd0;
                out_year_reg  <= 14'd0;
            end
            out_ovf_reg <= is_add && ovf_reg;
            out_dn_reg  <= acc_sat[22:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_day    = out_day_reg;
    assign result_month  = out_month_reg;
    assign result_year   = out_year_reg;
    assign day_number    = out_dn_reg;
    assign year_overflow = out_ovf_reg;

    a_step_month: assert property (@(posedge clk) disable iff (!rst_n)
        (op == gda_pkg::OP_STEP) |-> ((m_reg >= 4'd1) && (m_reg <= 4'd12)))
        else $error("month left 1..12 during day stepping");

    a_step_year: assert property (@(posedge clk) disable iff (!rst_n)
        (op == gda_pkg::OP_STEP && !ovf_reg) |-> (y_reg <= gda_pkg::YEAR_LIMIT))
        else $error("year passed limit without overflow flag");

    a_split_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (op == gda_pkg::OP_SPLIT) |=> (r100_reg < 7'd100))
        else $error("year remainder by 100 out of range");

    a_fin_day: assert property (@(posedge clk) disable iff (!rst_n)
        (op == gda_pkg::OP_FINISH && is_add && !ovf_reg) |-> (d_reg <= 17'd31))
        else $error("sum date day not reduced to a month");

endmodule

FILE: rtl/gregorian_date_arithmetic_top.sv
// Flow after an accepted word: LOAD1, MUL and SPLIT on the first date; day-of-year then runs
// DOY, difference runs TERM, SUB_S, LOAD2, MUL, SPLIT, TERM and ADD_S, and add-days runs the
// STEP microloop of month and whole-year steps (one step a cycle); all end in FINISH.
// Throughput: one item in flight; the next word is taken once the sequencer is back at idle
// after the result is registered; a held result word adds its wait.
// Reset: rst_n clears the microcode counter to idle and empties the result slot.
module gregorian_date_arithmetic_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_day, first_month, first_year, second_day, second_month,
    // second_year, day_count, 2 zero bits
    input  logic [63:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_day, result_month, result_year, day_number, 2 zero bits
    output logic [47:0] m_tdata,
    // year_overflow
    output logic [0:0]  m_tuser
);

    gda_pkg::op_t        op;
    gda_pkg::dp_status_t status;
    logic                idle;
    logic                start;
    logic [4:0]          result_day;
    logic [3:0]          result_month;
    logic [13:0]         result_year;
    logic [22:0]         day_number;
    logic                year_overflow;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    gda_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .idle   (idle)
    );

    gda_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .op              (op),
        .in_kind         (s_tuser),
        .in_first_day    (s_tdata[4:0]),
        .in_first_month  (s_tdata[8:5]),
        .in_first_year   (s_tdata[22:9]),
        .in_second_day   (s_tdata[27:23]),
        .in_second_month (s_tdata[31:28]),
        .in_second_year  (s_tdata[45:32]),
        .in_day_count    (s_tdata[61:46]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year),
        .day_number      (day_number),
        .year_overflow   (year_overflow),
        .status          (status)
    );

    assign m_tdata = {2'b00, day_number, result_year, result_month, result_day};
    assign m_tuser = year_overflow;

endmodule

FILE: bench/tb_gregorian_date_arithmetic_top.sv
`timescale 1ns / 100ps

module tb_gregorian_date_arithmetic_top;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int TAIL_CYCLES = 250;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  d1;
        logic [3:0]  m1;
        logic [13:0] y1;
        logic [4:0]  d2;
        logic [3:0]  m2;
        logic [13:0] y2;
        logic [15:0] count;
    } date_word_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [22:0] day_number;
        logic        overflow;
    } date_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // first_day, first_month, first_year, second_day, second_month,
    // second_year, day_count, 2 zero bits
    logic [63:0] s_tdata = '0;
    // kind
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // result_day, result_month, result_year, day_number, 2 zero bits
    logic [47:0] m_tdata;
    // year_overflow
    logic [0:0]  m_tuser;

    date_word_t   pending_words[$];
    date_result_t expected_results[$];
    date_word_t   offered_word;

    int  words_taken = 0;
    int  results_checked = 0;
    int  overflow_results = 0;
    int  error_count = 0;
    int  kind_seen[4] = '{0, 0, 0, 0};
    int  send_gap = 0;
    int  send_calm = 0;
    int  recv_stall = 0;
    int  recv_calm = 0;
    logic hold_off = 1'b0;

    gregorian_date_arithmetic_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        bit leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned fix_month(logic [3:0] m);
        if (m == 4'd0)
        begin
            return 1;
        end
        if (m > 4'd12)
        begin
            return 12;
        end
        return m;
    endfunction

    // month is clamped here; day is added as given, even past month end
    function automatic int unsigned ordinal(logic [4:0] d, logic [3:0] m, logic [13:0] y);
        int unsigned sum;
        int unsigned mc;
        sum = d;
        mc = fix_month(m);
        for (int unsigned k = 1; k < mc; k++)
        begin
            sum += month_days(k, y);
        end
        return sum;
    endfunction

    // day serial counted from year 0, which is a leap year
    function automatic longint day_serial(logic [4:0] d, logic [3:0] m, logic [13:0] y);
        longint p;
        longint leaps;
        leaps = 0;
        if (y > 0)
        begin
            p = y - 1;
            leaps = p / 4 - p / 100 + p / 400 + 1;
        end
        return 365 * longint'(y) + leaps + ordinal(d, m, y);
    endfunction

    function automatic date_result_t calendar_result(date_word_t w);
        date_result_t res;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned len;
        bit ovf;
        longint span;
        res = '0;
        case (w.kind)
            gda_pkg::KIND_ADD:
            begin
                d = w.d1 + w.count;
                m = fix_month(w.m1);
                y = w.y1;
                ovf = (y > gda_pkg::YEAR_LIMIT);
                while (!ovf)
                begin
                    len = month_days(m, y);
                    if (d <= len)
                    begin
                        break;
                    end
                    d -= len;
                    m++;
                    if (m > 12)
                    begin
                        m = 1;
                        y++;
                        ovf = (y > gda_pkg::YEAR_LIMIT);
                    end
                end
                if (ovf)
                begin
                    d = 31;
                    m = 12;
                    y = gda_pkg::YEAR_LIMIT;
                end
                res.day = d[4:0];
                res.month = m[3:0];
                res.year = y[13:0];
                res.overflow = ovf;
            end
            gda_pkg::KIND_DIFF:
            begin
                span = day_serial(w.d2, w.m2, w.y2) - day_serial(w.d1, w.m1, w.y1);
                if (span > 4194303)
                begin
                    span = 4194303;
                end
                if (span < -4194304)
                begin
                    span = -4194304;
                end
                res.day_number = span[22:0];
            end
            gda_pkg::KIND_DOY:
            begin
                res.day_number = 23'(ordinal(w.d1, w.m1, w.y1));
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic date_word_t make_word(logic [1:0] k, int d1, int m1, int y1,
                                             int d2, int m2, int y2, int cnt);
        date_word_t w;
        w.kind = k;
        w.d1 = d1[4:0];
        w.m1 = m1[3:0];
        w.y1 = y1[13:0];
        w.d2 = d2[4:0];
        w.m2 = m2[3:0];
        w.y2 = y2[13:0];
        w.count = cnt[15:0];
        return w;
    endfunction

    function automatic date_word_t random_word();
        date_word_t w;
        logic [63:0] raw;
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            // raw noise: any bit pattern, unknown kind included
            raw = {$urandom, $urandom};
            w = raw[$bits(date_word_t)-1:0];
            return w;
        end
        w.kind = 2'($urandom_range(0, 2));
        w.y1 = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(9700, 9999))
                                            : 14'($urandom_range(1601, 9999));
        w.m1 = 4'($urandom_range(1, 12));
        w.d1 = 5'($urandom_range(1, month_days(w.m1, w.y1)));
        w.y2 = 14'($urandom_range(1601, 9999));
        w.m2 = 4'($urandom_range(1, 12));
        w.d2 = 5'($urandom_range(1, month_days(w.m2, w.y2)));
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            w.count = 16'($urandom_range(0, 40));
        end
        else if (r < 7)
        begin
            w.count = 16'($urandom_range(0, 1000));
        end
        else
        begin
            w.count = 16'($urandom);
        end
        return w;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        date_word_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(calendar_result(offered_word));
                kind_seen[offered_word.kind]++;
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    nxt = pending_words.pop_front();
                    offered_word = nxt;
                    s_tdata <= {2'b00, nxt.count, nxt.y2, nxt.m2, nxt.d2,
                                nxt.y1, nxt.m1, nxt.d1};
                    s_tuser <= nxt.kind;
                    s_tvalid <= 1'b1;
                    send_gap = idle_length(send_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        date_result_t got;
        date_result_t want;
        logic rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.day = m_tdata[4:0];
                got.month = m_tdata[8:5];
                got.year = m_tdata[22:9];
                got.day_number = m_tdata[45:23];
                got.overflow = m_tuser[0];
                if (got.overflow === 1'b1)
                begin
                    overflow_results++;
                end
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf("result with nothing expected: %0d/%0d/%0d n=%0d ovf=%0b",
                        got.day, got.month, got.year, $signed(got.day_number), got.overflow));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.day !== want.day || got.month !== want.month ||
                        got.year !== want.year || got.day_number !== want.day_number ||
                        got.overflow !== want.overflow)
                    begin
                        flag_error($sformatf(
                            "result %0d: expected %0d/%0d/%0d n=%0d ovf=%0b, got %0d/%0d/%0d n=%0d ovf=%0b",
                            results_checked, want.day, want.month, want.year,
                            $signed(want.day_number), want.overflow, got.day, got.month,
                            got.year, $signed(got.day_number), got.overflow));
                    end
                end
                results_checked++;
            end
            if (hold_off)
            begin
                rdy = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rdy = 1'b0;
            end
            else
            begin
                recv_stall = idle_length(recv_calm);
                rdy = (recv_stall == 0);
                if (!rdy)
                begin
                    recv_stall--;
                end
            end
            m_tready <= rdy;
        end
    end

    // long receiver hold-off while the sender keeps offering words
    initial
    begin
        while (words_taken < 40)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int total_words;
        // leap rules, year carry, overflow and the limits of every field
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 1, 1, 1601, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 31, 12, 9999, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 31, 12, 9999, 0, 0, 0, 1));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 28, 2, 2000, 0, 0, 0, 1));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 28, 2, 1900, 0, 0, 0, 1));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 1, 1, 1601, 0, 0, 0, 65535));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 0, 1, 2023, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 15, 0, 2023, 0, 0, 0, 20));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 15, 15, 2023, 0, 0, 0, 20));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 1, 1, 12000, 0, 0, 0, 5));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 31, 2, 2021, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 28, 2, 0, 0, 0, 0, 1));
        pending_words.push_back(make_word(gda_pkg::KIND_ADD, 31, 15, 16383, 31, 15, 16383,
                                          65535));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 1, 1, 1601, 31, 12, 9999, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 31, 12, 9999, 1, 1, 1601, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 0, 0, 0, 31, 15, 16383, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 31, 15, 16383, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 29, 2, 2024, 29, 2, 2024, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DIFF, 10, 0, 1999, 10, 15, 1999, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DOY, 31, 12, 2000, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DOY, 31, 12, 1999, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DOY, 1, 1, 1601, 0, 0, 0, 0));
        pending_words.push_back(make_word(gda_pkg::KIND_DOY, 31, 15, 16383, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_UNUSED, 31, 15, 16383, 31, 15, 16383, 65535));
        pending_words.push_back(make_word(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        repeat (480)
        begin
            pending_words.push_back(random_word());
        end
        total_words = pending_words.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < total_words || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d words: %0d add-days, %0d difference, %0d day-of-year, %0d unknown kind",
                 words_taken, kind_seen[gda_pkg::KIND_ADD], kind_seen[gda_pkg::KIND_DIFF],
                 kind_seen[gda_pkg::KIND_DOY], kind_seen[KIND_UNUSED]);
        $display("%0d results checked, %0d with year overflow, %0d errors",
                 results_checked, overflow_results, error_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gda_pkg.sv
rtl/gda_seq.sv
rtl/gda_dp.sv
rtl/gregorian_date_arithmetic_top.sv
bench/tb_gregorian_date_arithmetic_top.sv
